### src/utf8d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_pkg
// Beat types and byte-class constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned CpW = 31;

  // Byte class boundaries and payload masks
  localparam logic [7:0] ContLo   = 8'h80;
  localparam logic [7:0] Lead2Lo  = 8'hc0;
  localparam logic [7:0] Lead3Lo  = 8'he0;
  localparam logic [7:0] Lead4Lo  = 8'hf0;
  localparam logic [7:0] Lead5Lo  = 8'hf8;
  localparam logic [7:0] Lead6Lo  = 8'hfc;
  localparam logic [7:0] ContMask = 8'h3f;

  // Replacement character '?'
  localparam logic [CpW-1:0] ReplChar = CpW'(63);

  // Depth of the result queue
  localparam int unsigned OutDepth = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_t;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           is_replacement;
    logic           last_of_run;
  } out_t;

endpackage

### src/utf8_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Byte-serial UTF-8 decoder with legacy 5- and 6-byte forms; malformed input
// yields '?' flagged as a replacement.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the input is not stalled. An accepted byte
// sits in an input register, is decoded there against the sequence state, and
// its zero, one or two results enter a four-entry result queue on the edge that
// takes it out of that register; the first result can leave the cycle after that.
// Output drains one result per cycle while out_stall_i is low, so the sustained
// rate is one byte per cycle as long as bytes average no more than one result;
// the queue absorbs bytes that give two results. The input stalls only when
// the queue lacks room for the results of the byte held in the input register.
module utf8_stream_decoder #(
  parameter int unsigned OutDepth = utf8d_pkg::OutDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  utf8d_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output utf8d_pkg::out_t out_data_o
);

  localparam int unsigned PtrW = (OutDepth > 1) ? $clog2(OutDepth) : 1;
  localparam int unsigned CntW = $clog2(OutDepth + 1);
  localparam int unsigned CpW  = utf8d_pkg::CpW;

  typedef struct packed {
    logic           emit;
    logic [CpW-1:0] cp;
    logic           repl;
    logic           skip;
    logic [2:0]     pend;
    logic [CpW-1:0] part;
  } start_t;

  // Decode a byte that does not continue a pending sequence
  function automatic start_t start_dec(input logic [7:0] b);
    start_t s;
    s = '0;
    priority if (b < utf8d_pkg::ContLo) begin
      s.emit = 1'b1;
      s.cp   = CpW'(b);
    end else if (b < utf8d_pkg::Lead2Lo) begin
      s.emit = 1'b1;
      s.cp   = utf8d_pkg::ReplChar;
      s.repl = 1'b1;
      s.skip = 1'b1;
    end else if (b < utf8d_pkg::Lead3Lo) begin
      s.pend = 3'd1;
      s.part = CpW'(b[4:0]);
    end else if (b < utf8d_pkg::Lead4Lo) begin
      s.pend = 3'd2;
      s.part = CpW'(b[3:0]);
    end else if (b < utf8d_pkg::Lead5Lo) begin
      s.pend = 3'd3;
      s.part = CpW'(b[2:0]);
    end else if (b < utf8d_pkg::Lead6Lo) begin
      s.pend = 3'd4;
      s.part = CpW'(b[1:0]);
    end else begin
      s.pend = 3'd5;
      s.part = CpW'(b[0]);
    end
    return s;
  endfunction

  // Advance a queue pointer by up to two entries, wrapping at the depth
  function automatic logic [PtrW-1:0] ptr_add(input logic [PtrW-1:0] p,
                                               input logic [1:0]      inc);
    logic [PtrW+1:0] sum;
    sum = {2'b00, p} + {PtrW'(0), inc};
    if (sum >= (PtrW+2)'(OutDepth)) begin
      sum = sum - (PtrW+2)'(OutDepth);
    end
    return sum[PtrW-1:0];
  endfunction

  // Input register
  logic           in_vld_q;
  utf8d_pkg::in_t in_q;

  // Sequence state
  logic [2:0]     pend_q, pend_d;
  logic [CpW-1:0] part_q, part_d;
  logic           skip_q, skip_d;

  // Result queue
  utf8d_pkg::out_t mem_q [OutDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  // Decode results of the registered byte
  logic           res_vld [2];
  logic [CpW-1:0] res_cp  [2];
  logic           res_rpl [2];
  logic [1:0]     nres;
  logic           proc;
  logic           pop;
  logic           in_acc;

  // Decode the held byte against the sequence state
  always_comb begin
    logic [7:0] b;
    logic       cont;
    start_t     s;
    b       = in_q.in_byte;
    cont    = (b >= utf8d_pkg::ContLo) && (b < utf8d_pkg::Lead2Lo);
    s       = start_dec(b);
    pend_d  = pend_q;
    part_d  = part_q;
    skip_d  = skip_q;
    nres    = 2'd0;
    for (int k = 0; k < 2; k++) begin
      res_vld[k] = 1'b0;
      res_cp[k]  = '0;
      res_rpl[k] = 1'b0;
    end
    if (pend_q != 3'd0) begin
      if (cont) begin
        part_d = {part_q[CpW-7:0], b[5:0] & utf8d_pkg::ContMask[5:0]};
        pend_d = pend_q - 3'd1;
        if (pend_d == 3'd0) begin
          res_vld[0] = 1'b1;
          res_cp[0]  = part_d;
          nres       = 2'd1;
          part_d     = '0;
        end
      end else begin
        // Broken sequence: replace, then decode the byte as a new lead
        res_vld[0] = 1'b1;
        res_cp[0]  = utf8d_pkg::ReplChar;
        res_rpl[0] = 1'b1;
        nres       = 2'd1;
        pend_d     = s.pend;
        part_d     = s.part;
        if (s.skip) begin
          skip_d = 1'b1;
        end
        if (s.emit) begin
          res_vld[1] = 1'b1;
          res_cp[1]  = s.cp;
          res_rpl[1] = s.repl;
          nres       = 2'd2;
        end
      end
    end else if (skip_q && cont) begin
      // drop the continuation byte
      nres = 2'd0;
    end else begin
      skip_d = s.skip;
      pend_d = s.pend;
      part_d = s.part;
      if (s.emit) begin
        res_vld[0] = 1'b1;
        res_cp[0]  = s.cp;
        res_rpl[0] = s.repl;
        nres       = 2'd1;
      end
    end
    // Flush a truncated sequence at end of stream
    if (in_q.end_of_stream) begin
      if (pend_d != 3'd0) begin
        res_vld[nres[0]] = 1'b1;
        res_cp[nres[0]]  = utf8d_pkg::ReplChar;
        res_rpl[nres[0]] = 1'b1;
        nres             = nres + 2'd1;
      end
      pend_d = 3'd0;
      part_d = '0;
      skip_d = 1'b0;
    end
  end

  // Handshakes
  assign proc        = in_vld_q && ((32'(cnt_q) + 32'(nres)) <= OutDepth);
  assign in_stall_o  = in_vld_q && !proc;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  // Hold the input beat and the sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      pend_q   <= 3'd0;
      part_q   <= '0;
      skip_q   <= 1'b0;
    end else begin
      if (in_acc) begin
        in_vld_q <= 1'b1;
      end else if (proc) begin
        in_vld_q <= 1'b0;
      end
      if (proc) begin
        pend_q <= pend_d;
        part_q <= part_d;
        skip_q <= skip_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_data_i;
    end
  end

  // Advance queue pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (proc) begin
        wr_ptr_q <= ptr_add(wr_ptr_q, nres);
      end
      if (pop) begin
        rd_ptr_q <= ptr_add(rd_ptr_q, 2'd1);
      end
      cnt_q <= CntW'(32'(cnt_q) + (proc ? 32'(nres) : 32'd0) - (pop ? 32'd1 : 32'd0));
    end
  end

  // Write results into the queue
  always_ff @(posedge clk_i) begin
    if (proc) begin
      for (int k = 0; k < 2; k++) begin
        if (res_vld[k]) begin
          mem_q[ptr_add(wr_ptr_q, 2'(k))] <= '{
            code_point:     res_cp[k],
            is_replacement: res_rpl[k],
            last_of_run:    (32'(k) + 32'd1 == 32'(nres))
          };
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= OutDepth)
    else $error("result queue overflow");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd5)
    else $error("pending count out of range");

  a_eos_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && in_q.end_of_stream |=> pend_q == 3'd0 && !skip_q && part_q == '0)
    else $error("state not cleared after end of stream");
`endif

endmodule

### verif/utf8_stream_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_tb
// Self-checking bench for the byte-serial UTF-8 decoder.
// ----------------------------------------------------------------------------
// A queue of bytes, filled up front, feeds a clocked driver. Every accepted
// byte runs through a behavioral decoder that queues the characters it should
// produce. A clocked monitor pops them in order and compares every field.
// The stimulus is a short directed run of edge cases, then mostly well-formed
// sequences of 1 to 6 bytes with random payloads, mixed with raw noise and
// cut-off sequences. Both sides idle in short random bursts. Once, the output
// side stalls for a long stretch so that the result queue fills and the input
// stalls. The tail of the run has no idling.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_tb;

  localparam int unsigned RandomBytes = 1800;
  localparam int unsigned QuietTail   = 150;   // bytes left when idling stops
  localparam int unsigned HoldAt      = 600;   // bytes in before the long stall
  localparam int unsigned HoldCycles  = 40;
  localparam int unsigned IdleLimit   = 1000;  // cycles with no beat on either side
  localparam int unsigned DrainCycles = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic            in_valid = 1'b0;
  logic            in_stall;
  utf8d_pkg::in_t  in_data = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  utf8d_pkg::out_t out_data;

  // Stimulus and expected characters
  utf8d_pkg::in_t  byte_q[$];
  utf8d_pkg::out_t expected_chars[$];

  // Decoder state as the bench tracks it
  logic [2:0]                exp_pending = '0;
  logic [utf8d_pkg::CpW-1:0] exp_partial = '0;
  logic                      exp_skip    = 1'b0;

  int unsigned     beats_in    = 0;
  int unsigned     in_gap      = 0;
  int unsigned     out_gap     = 0;
  int unsigned     hold_left   = 0;
  logic            hold_done   = 1'b0;
  int unsigned     idle_cycles = 0;
  int unsigned     err_cnt     = 0;
  utf8d_pkg::out_t want;

  utf8_stream_decoder dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Behavioral decoder
  // --------------------------------------------------------------------------

  // Decode a byte that opens something new; return 1 if it yields a character
  function automatic logic start_lead(input logic [7:0] b, output utf8d_pkg::out_t r);
    r = '0;
    if (b < utf8d_pkg::ContLo) begin
      r.code_point = utf8d_pkg::CpW'(b);
      return 1'b1;
    end
    if (b < utf8d_pkg::Lead2Lo) begin
      r.code_point     = utf8d_pkg::ReplChar;
      r.is_replacement = 1'b1;
      exp_skip         = 1'b1;
      return 1'b1;
    end
    if (b < utf8d_pkg::Lead3Lo) begin
      exp_pending = 3'd1;
      exp_partial = utf8d_pkg::CpW'(b[4:0]);
    end else if (b < utf8d_pkg::Lead4Lo) begin
      exp_pending = 3'd2;
      exp_partial = utf8d_pkg::CpW'(b[3:0]);
    end else if (b < utf8d_pkg::Lead5Lo) begin
      exp_pending = 3'd3;
      exp_partial = utf8d_pkg::CpW'(b[2:0]);
    end else if (b < utf8d_pkg::Lead6Lo) begin
      exp_pending = 3'd4;
      exp_partial = utf8d_pkg::CpW'(b[1:0]);
    end else begin
      exp_pending = 3'd5;
      exp_partial = utf8d_pkg::CpW'(b[0]);
    end
    return 1'b0;
  endfunction

  // Advance the decoder by one byte and queue the characters it yields
  task automatic decode_byte(input utf8d_pkg::in_t beat);
    utf8d_pkg::out_t run [2];
    utf8d_pkg::out_t r;
    int unsigned     n;
    logic            cont;
    n    = 0;
    cont = (beat.in_byte >= utf8d_pkg::ContLo) && (beat.in_byte < utf8d_pkg::Lead2Lo);
    if (exp_pending != 3'd0) begin
      if (cont) begin
        exp_partial = {exp_partial[utf8d_pkg::CpW-7:0], beat.in_byte[5:0]};
        exp_pending = exp_pending - 3'd1;
        if (exp_pending == 3'd0) begin
          run[n] = '{code_point: exp_partial, is_replacement: 1'b0, last_of_run: 1'b0};
          n++;
          exp_partial = '0;
        end
      end else begin
        run[n] = '{code_point: utf8d_pkg::ReplChar, is_replacement: 1'b1,
                   last_of_run: 1'b0};
        n++;
        exp_pending = '0;
        exp_partial = '0;
        if (start_lead(beat.in_byte, r)) begin
          run[n] = r;
          n++;
        end
      end
    end else if (!(exp_skip && cont)) begin
      exp_skip = 1'b0;
      if (start_lead(beat.in_byte, r)) begin
        run[n] = r;
        n++;
      end
    end
    // Flush a cut-off sequence and start over at end of stream
    if (beat.end_of_stream) begin
      if (exp_pending != 3'd0) begin
        run[n] = '{code_point: utf8d_pkg::ReplChar, is_replacement: 1'b1,
                   last_of_run: 1'b0};
        n++;
      end
      exp_pending = '0;
      exp_partial = '0;
      exp_skip    = 1'b0;
    end
    if (n > 0) run[n-1].last_of_run = 1'b1;
    for (int k = 0; k < n; k++) expected_chars.push_back(run[k]);
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic push_beat(input logic [7:0] b, input logic eos);
    utf8d_pkg::in_t beat;
    beat.in_byte       = b;
    beat.end_of_stream = eos;
    byte_q.push_back(beat);
  endtask

  // Push the first keep bytes of a len-byte sequence; eos marks the last one
  task automatic push_seq(input int unsigned len, input int unsigned keep,
                          input logic eos);
    logic [7:0] lead;
    case (len)
      1:       lead = 8'($urandom_range(0, 127));
      2:       lead = utf8d_pkg::Lead2Lo | 8'($urandom_range(0, 31));
      3:       lead = utf8d_pkg::Lead3Lo | 8'($urandom_range(0, 15));
      4:       lead = utf8d_pkg::Lead4Lo | 8'($urandom_range(0, 7));
      5:       lead = utf8d_pkg::Lead5Lo | 8'($urandom_range(0, 3));
      default: lead = utf8d_pkg::Lead6Lo | 8'($urandom_range(0, 3));
    endcase
    push_beat(lead, eos && keep == 1);
    for (int k = 1; k < keep; k++)
      push_beat(utf8d_pkg::ContLo | 8'($urandom_range(0, 63)), eos && k == keep - 1);
  endtask

  // --------------------------------------------------------------------------
  // Driver: present the next byte, hold it while stalled
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        decode_byte(in_data);
        beats_in <= beats_in + 1;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap   = in_gap - 1;
          in_valid <= 1'b0;
        end else if (byte_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (hold_left == 0 && byte_q.size() >= QuietTail &&
                     $urandom_range(0, 5) == 0) begin
          in_gap   = $urandom_range(0, 2);
          in_valid <= 1'b0;
        end else begin
          in_data  <= byte_q.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each accepted beat, then decide the next stall
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected result: code_point 0x%0h", out_data.code_point);
          err_cnt++;
        end else begin
          want = expected_chars.pop_front();
          compare_field("code_point", 32'(want.code_point), 32'(out_data.code_point));
          compare_field("is_replacement", 32'(want.is_replacement),
                        32'(out_data.is_replacement));
          compare_field("last_of_run", 32'(want.last_of_run), 32'(out_data.last_of_run));
        end
      end

      // Long hold-off once, otherwise short random bursts until the quiet tail
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && beats_in >= HoldAt) begin
        hold_done <= 1'b1;
        hold_left <= HoldCycles;
        out_stall <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap   <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (byte_q.size() >= QuietTail && $urandom_range(0, 5) == 0) begin
        out_gap   <= $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run if no beat moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int unsigned pick;
    int unsigned len;

    // Directed: ASCII extremes, min and max multi-byte forms
    push_beat(8'h00, 1'b0);
    push_beat(8'h7f, 1'b0);
    push_beat(8'hc0, 1'b0);
    push_beat(8'h80, 1'b0);
    push_beat(8'hdf, 1'b0);
    push_beat(8'hbf, 1'b0);
    push_beat(8'hef, 1'b0);
    push_beat(8'hbf, 1'b0);
    push_beat(8'hbf, 1'b0);
    // Six-byte form from 0xff, giving the widest code point
    push_beat(8'hff, 1'b0);
    repeat (5) push_beat(8'hbf, 1'b0);
    // Stray continuation, one dropped, then plain ASCII
    push_beat(8'h80, 1'b0);
    push_beat(8'hbf, 1'b0);
    push_beat(8'h41, 1'b0);
    // Broken sequence: ASCII inside a three-byte form
    push_beat(8'he2, 1'b0);
    push_beat(8'h41, 1'b0);
    // Broken sequence whose new lead is cut off by end of stream
    push_beat(8'hc3, 1'b0);
    push_beat(8'hf8, 1'b1);
    // Stray continuation at end of stream; the next one is stray again
    push_beat(8'h80, 1'b1);
    push_beat(8'h80, 1'b0);

    // Random: mostly well-formed sequences, some noise and cut-off ones
    while (byte_q.size() < RandomBytes) begin
      pick = $urandom_range(0, 9);
      len  = $urandom_range(1, 6);
      if (pick < 7) begin
        push_seq(len, len, $urandom_range(0, 19) == 0);
      end else if (pick < 9) begin
        push_beat(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
      end else begin
        if (len < 2) len = 2;
        push_seq(len, $urandom_range(1, len - 1), $urandom_range(0, 3) == 0);
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every byte to go in and every character to come out
    do @(posedge clk);
    while (byte_q.size() != 0 || in_valid || expected_chars.size() != 0);
    repeat (DrainCycles) @(posedge clk);

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
src/utf8d_pkg.sv
src/utf8_stream_decoder.sv
verif/utf8_stream_decoder_tb.sv
